[design/lms_pkg.sv]
// Package for the 3x3 local-maximum suppression block: shared constants,
// register indexes and the job control word between the front and back ends.
// No dependencies.
package lms_pkg;

	localparam int ROW_BITS       = 12;
	localparam int HEIGHT_BITS    = 13;
	localparam int WIDTH_REG_BITS = 7;
	localparam int SLOT_BITS      = 2;
	localparam int COLUMN_OUT_BITS = 6;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 13;
	localparam int MAX_HEIGHT     = 4096;
	localparam int MIN_SIZE       = 3;
	localparam int RESET_WIDTH    = 64;
	localparam int RESET_HEIGHT   = 64;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BORDER = 2'd2;

	localparam logic [SLOT_BITS-1:0] SLOT_0 = 2'd0;
	localparam logic [SLOT_BITS-1:0] SLOT_1 = 2'd1;
	localparam logic [SLOT_BITS-1:0] SLOT_2 = 2'd2;

	// One column event for the row being decided.
	typedef struct packed {
		logic [ROW_BITS-1:0]  row;       // row whose positions are decided
		logic [SLOT_BITS-1:0] slot;      // line buffer slot of the row below it
		logic                 row_end;   // last column of the row
		logic                 frame_end; // last pixel of the frame
	} job_ctl_t;

endpackage

[design/lms_pixel_if.sv]
// Input channel of the local-maximum block: one pixel word per handshake.
// Depends on nothing.
interface lms_pixel_if #(
	parameter int PIXEL_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [PIXEL_BITS-1:0] pixel_value;

	modport source (output valid, output pixel_value, input ready);
	modport sink (input valid, input pixel_value, output ready);
endinterface

[design/lms_result_if.sv]
// Output channel of the local-maximum block: one reported maximum per word.
// Depends on nothing.
interface lms_result_if #(
	parameter int PIXEL_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic [11:0]                  max_row;
	logic [5:0]                   max_column;
	logic signed [PIXEL_BITS-1:0] max_value;
	logic                         last_of_run;

	modport source (output valid, output max_row, output max_column,
		output max_value, output last_of_run, input ready);
	modport sink (input valid, input max_row, input max_column,
		input max_value, input last_of_run, output ready);
endinterface

[design/local_max_suppression_3x3.sv]
// Flow: a pixel's column job reaches the back end through a two-word queue; it is popped
// with a line buffer read and decided in ST_DEC, with an ST_END step at a row end and an
// ST_FIN step when the job leaves a maximum to report; the result port can stall a decision.
// The back end takes a new job only once it has finished the last one (read-then-decide
// loop); the last pixel of a frame adds a sweep of the bottom row.
// Reset: registers return to width 64, height 64, border mode off; counters and control clear.
module local_max_suppression_3x3 #(
	parameter int MAX_WIDTH  = 64,
	parameter int PIXEL_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	lms_pixel_if.sink                          pixels,
	lms_result_if.source                       maxima,
	input  logic                               cfg_wr_en,
	input  logic [lms_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [lms_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import lms_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH+1);

	// Front to queue.
	logic [2:0]             line_we;
	logic [CW-1:0]          line_waddr;
	logic [PIXEL_BITS-1:0]  line_wdata;
	logic                   q_push;
	logic [CW-1:0]          q_push_col;
	job_ctl_t               q_push_ctl;
	logic                   q_full;

	// Queue to back.
	logic                   q_valid;
	logic [CW-1:0]          q_col;
	job_ctl_t               q_ctl;
	logic                   q_pop;

	// Shared configuration and back-end line buffer reads.
	logic [WW-1:0]          eff_w;
	logic [HEIGHT_BITS-1:0] eff_h;
	logic                   border;
	logic                   line_re;
	logic [CW-1:0]          line_raddr;
	logic [PIXEL_BITS-1:0]  rd_data [3];
	logic                   frame_done;

	// The front end counts the raster position, writes each pixel into the
	// line buffer of its row and issues one column job per pixel from the
	// second row on.
	lms_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.pixels     (pixels),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.q_full     (q_full),
		.frame_done (frame_done),
		.line_we    (line_we),
		.line_waddr (line_waddr),
		.line_wdata (line_wdata),
		.q_push     (q_push),
		.q_col      (q_push_col),
		.q_ctl      (q_push_ctl),
		.eff_w      (eff_w),
		.eff_h      (eff_h),
		.border     (border)
	);

	lms_queue #(.MAX_WIDTH(MAX_WIDTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_col   (q_push_col),
		.push_ctl   (q_push_ctl),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_col   (q_col),
		.head_ctl   (q_ctl),
		.full       (q_full)
	);

	// Three rotating line buffers hold the rows above, at and below the
	// row being decided. The queue depth keeps the front at most two
	// columns ahead, so it never overwrites a column still to be read.
	for (genvar i = 0; i < 3; i++) begin : g_line
		lms_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_line (
			.clk   (clk),
			.we    (line_we[i]),
			.waddr (line_waddr),
			.wdata (line_wdata),
			.re    (line_re),
			.raddr (line_raddr),
			.rdata (rd_data[i])
		);
	end

	// The back end slides the window one column per job, and across the whole
	// bottom row for a frame's last job, decides the centre column and holds
	// one result back so that the final word of each pixel carries last_of_run.
	lms_back #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_col      (q_col),
		.q_ctl      (q_ctl),
		.q_pop      (q_pop),
		.eff_w      (eff_w),
		.eff_h      (eff_h),
		.border     (border),
		.line_re    (line_re),
		.line_raddr (line_raddr),
		.rd_data    (rd_data),
		.frame_done (frame_done),
		.maxima     (maxima)
	);
endmodule

[design/lms_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module lms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

[design/lms_queue.sv]
// Two-entry job queue between the front and back ends.
// Depends on lms_pkg.
module lms_queue #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [$clog2(MAX_WIDTH)-1:0]  push_col,
	input  lms_pkg::job_ctl_t             push_ctl,
	input  logic                          pop,
	output logic                          head_valid,
	output logic [$clog2(MAX_WIDTH)-1:0]  head_col,
	output lms_pkg::job_ctl_t             head_ctl,
	output logic                          full
);
	import lms_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic [CW-1:0] col_q [2];
	job_ctl_t      ctl_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    count_q;

	assign head_valid = count_q != 2'd0;
	assign full       = count_q == 2'd2;
	assign head_col   = col_q[rd_q];
	assign head_ctl   = ctl_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			col_q[wr_q] <= push_col;
			ctl_q[wr_q] <= push_ctl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end
endmodule

[design/lms_front.sv]
// Front end: configuration registers, raster counters, line buffer writes and
// column jobs for the back end. Depends on lms_pkg and lms_pixel_if.
module lms_front #(
	parameter int MAX_WIDTH  = 64,
	parameter int PIXEL_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	lms_pixel_if.sink                               pixels,
	input  logic                                    cfg_wr_en,
	input  logic [lms_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
	input  logic [lms_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	input  logic                                    q_full,
	input  logic                                    frame_done,
	output logic [2:0]                              line_we,
	output logic [$clog2(MAX_WIDTH)-1:0]            line_waddr,
	output logic [PIXEL_BITS-1:0]                   line_wdata,
	output logic                                    q_push,
	output logic [$clog2(MAX_WIDTH)-1:0]            q_col,
	output lms_pkg::job_ctl_t                       q_ctl,
	output logic [$clog2(MAX_WIDTH+1)-1:0]          eff_w,
	output logic [lms_pkg::HEIGHT_BITS-1:0]         eff_h,
	output logic                                    border
);
	import lms_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH+1);
	localparam int RESET_W = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

	logic [WW-1:0]          eff_w_q;
	logic [HEIGHT_BITS-1:0] eff_h_q;
	logic                   border_q;
	logic [CW-1:0]          col_q;
	logic [ROW_BITS-1:0]    row_q;
	logic [SLOT_BITS-1:0]   slot_q;
	logic                   busy_q;

	logic                      acc;
	logic                      last_col;
	logic                      last_row;
	logic [WIDTH_REG_BITS-1:0] w_in;
	logic [HEIGHT_BITS-1:0]    h_in;
	logic                      cfg_hit;

	assign eff_w  = eff_w_q;
	assign eff_h  = eff_h_q;
	assign border = border_q;

	// The front stops while the queue is full and while a frame's bottom
	// row is still being swept by the back end.
	assign pixels.ready = !q_full && !busy_q;
	assign acc          = pixels.valid && pixels.ready;

	assign last_col = WW'(col_q) == eff_w_q - WW'(1);
	assign last_row = HEIGHT_BITS'(row_q) == eff_h_q - HEIGHT_BITS'(1);

	assign w_in    = cfg_data[WIDTH_REG_BITS-1:0];
	assign h_in    = cfg_data;
	assign cfg_hit = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT
		|| cfg_index == REG_BORDER);

	always_comb begin
		line_we = 3'b000;
		if (acc) begin
			unique case (slot_q)
				SLOT_0:  line_we = 3'b001;
				SLOT_1:  line_we = 3'b010;
				default: line_we = 3'b100;
			endcase
		end
	end

	assign line_waddr        = col_q;
	assign line_wdata        = pixels.pixel_value;
	assign q_push            = acc && row_q != '0;
	assign q_col             = col_q;
	assign q_ctl.row         = row_q - ROW_BITS'(1);
	assign q_ctl.slot        = slot_q;
	assign q_ctl.row_end     = last_col;
	assign q_ctl.frame_end   = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_w_q  <= WW'(RESET_W);
			eff_h_q  <= HEIGHT_BITS'(RESET_HEIGHT);
			border_q <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= SLOT_0;
			busy_q   <= 1'b0;
		end else if (cfg_hit) begin
			case (cfg_index)
				REG_WIDTH: begin
					if (w_in < WIDTH_REG_BITS'(MIN_SIZE)) begin
						eff_w_q <= WW'(MIN_SIZE);
					end else if (int'(w_in) > MAX_WIDTH) begin
						eff_w_q <= WW'(MAX_WIDTH);
					end else begin
						eff_w_q <= WW'(w_in);
					end
				end
				REG_HEIGHT: begin
					if (h_in < HEIGHT_BITS'(MIN_SIZE)) begin
						eff_h_q <= HEIGHT_BITS'(MIN_SIZE);
					end else if (h_in > HEIGHT_BITS'(MAX_HEIGHT)) begin
						eff_h_q <= HEIGHT_BITS'(MAX_HEIGHT);
					end else begin
						eff_h_q <= h_in;
					end
				end
				default: begin
					border_q <= cfg_data[0];
				end
			endcase
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= SLOT_0;
			busy_q <= 1'b0;
		end else begin
			if (frame_done) begin
				busy_q <= 1'b0;
			end
			if (acc) begin
				if (q_push && q_ctl.frame_end) begin
					busy_q <= 1'b1;
				end
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						row_q  <= '0;
						slot_q <= SLOT_0;
					end else begin
						row_q  <= row_q + ROW_BITS'(1);
						slot_q <= (slot_q == SLOT_2) ? SLOT_0 : slot_q + SLOT_BITS'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
		end
	end
endmodule

[design/lms_back.sv]
// Back end: sliding 3x3 window over the line buffers, suppression flags,
// the local-maximum decision and the result register.
// Depends on lms_pkg, lms_ram and lms_result_if.
module lms_back #(
	parameter int MAX_WIDTH  = 64,
	parameter int PIXEL_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  logic [$clog2(MAX_WIDTH)-1:0]        q_col,
	input  lms_pkg::job_ctl_t                   q_ctl,
	output logic                                q_pop,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]      eff_w,
	input  logic [lms_pkg::HEIGHT_BITS-1:0]     eff_h,
	input  logic                                border,
	output logic                                line_re,
	output logic [$clog2(MAX_WIDTH)-1:0]        line_raddr,
	input  logic [PIXEL_BITS-1:0]               rd_data [3],
	output logic                                frame_done,
	lms_result_if.source                        maxima
);
	import lms_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH+1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_DEC  = 3'd2;
	localparam logic [2:0] ST_END  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	typedef logic signed [PIXEL_BITS-1:0] pix_t;

	logic [2:0]           state_q;
	logic [CW-1:0]        col_q;
	logic [ROW_BITS-1:0]  row_q;
	logic [SLOT_BITS-1:0] top_q;
	logic [SLOT_BITS-1:0] mid_q;
	logic [SLOT_BITS-1:0] bot_q;
	logic                 botv_q;
	logic                 rend_q;
	logic                 fend_q;
	logic                 flush_q;
	logic                 left_q;
	pix_t                 win_a_q [3];
	pix_t                 win_b_q [3];
	logic                 fa_q;
	logic                 fb_q;
	logic                 pend_v_q;
	logic [ROW_BITS-1:0]  pend_row_q;
	logic [COLUMN_OUT_BITS-1:0] pend_col_q;
	pix_t                 pend_val_q;
	logic                 out_v_q;
	logic [ROW_BITS-1:0]  out_row_q;
	logic [COLUMN_OUT_BITS-1:0] out_col_q;
	pix_t                 out_val_q;
	logic                 out_last_q;

	pix_t    newcol [3];
	logic    flag_rd;
	logic    in_dec;
	logic    in_end;
	logic [CW-1:0] dec_c;
	logic    has_dec;
	logic    lv;
	logic    rv;
	logic    tv;
	logic    sup;
	logic    tested;
	logic    exceed;
	logic    is_max;
	pix_t    centre;
	logic    out_free;
	logic    stall;
	logic    step;
	logic    job_last;
	logic    go_idle;

	function automatic pix_t pick(input logic [SLOT_BITS-1:0] s,
		input logic [PIXEL_BITS-1:0] d0, input logic [PIXEL_BITS-1:0] d1,
		input logic [PIXEL_BITS-1:0] d2);
		pix_t r;
		unique case (s)
			SLOT_0:  r = d0;
			SLOT_1:  r = d1;
			default: r = d2;
		endcase
		return r;
	endfunction

	assign q_pop      = state_q == ST_IDLE && q_valid;
	assign line_re    = q_pop || state_q == ST_RD;
	assign line_raddr = (state_q == ST_IDLE) ? q_col : col_q;

	lms_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_flags (
		.clk   (clk),
		.we    (step && has_dec),
		.waddr (dec_c),
		.wdata (is_max),
		.re    (line_re),
		.raddr (line_raddr),
		.rdata (flag_rd)
	);

	assign newcol[0] = pick(top_q, rd_data[0], rd_data[1], rd_data[2]);
	assign newcol[1] = pick(mid_q, rd_data[0], rd_data[1], rd_data[2]);
	assign newcol[2] = pick(bot_q, rd_data[0], rd_data[1], rd_data[2]);

	assign in_dec  = state_q == ST_DEC;
	assign in_end  = state_q == ST_END;
	assign dec_c   = in_dec ? col_q - CW'(1) : col_q;
	assign has_dec = in_end || (in_dec && col_q != '0);
	assign lv      = dec_c != '0;
	assign rv      = in_dec;
	assign tv      = row_q != '0;
	assign centre  = win_b_q[1];

	// Flags of the row above are meaningful only once a row of this frame
	// has been decided, which is exactly when the row above exists.
	assign sup = (fa_q && lv && tv) || (fb_q && tv) || (flag_rd && rv && tv)
		|| (left_q && lv);

	assign tested = border || (tv && lv
		&& (HEIGHT_BITS'(row_q) + HEIGHT_BITS'(2) <= eff_h)
		&& ((WW+1)'(dec_c) + (WW+1)'(2) <= (WW+1)'(eff_w)));

	always_comb begin
		logic rowv;
		exceed = 1'b0;
		for (int i = 0; i < 3; i++) begin
			rowv = (i == 0) ? tv : ((i == 2) ? botv_q : 1'b1);
			if (rowv && lv && win_a_q[i] > centre) exceed = 1'b1;
			if (rowv && i != 1 && win_b_q[i] > centre) exceed = 1'b1;
			if (rowv && rv && newcol[i] > centre) exceed = 1'b1;
		end
	end

	assign is_max   = has_dec && tested && !sup && !exceed;
	assign out_free = !out_v_q || maxima.ready;
	assign stall    = is_max && pend_v_q && !out_free;
	assign step     = (in_dec || in_end) && !stall;

	// Last decision of the job this step: plain column, or row end without
	// a frame flush still to come.
	assign job_last = step && ((in_dec && !flush_q && !rend_q)
		|| (in_end && !(fend_q && !flush_q)));
	assign go_idle  = (job_last && !(pend_v_q || is_max))
		|| (state_q == ST_FIN && out_free);
	assign frame_done = go_idle && flush_q;

	assign maxima.valid       = out_v_q;
	assign maxima.max_row     = out_row_q;
	assign maxima.max_column  = out_col_q;
	assign maxima.max_value   = out_val_q;
	assign maxima.last_of_run = out_last_q;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			col_q  <= q_col;
			row_q  <= q_ctl.row;
			bot_q  <= q_ctl.slot;
			mid_q  <= (q_ctl.slot == SLOT_0) ? SLOT_2 : q_ctl.slot - SLOT_BITS'(1);
			top_q  <= (q_ctl.slot == SLOT_2) ? SLOT_0 : q_ctl.slot + SLOT_BITS'(1);
			botv_q <= 1'b1;
			rend_q <= q_ctl.row_end;
			fend_q <= q_ctl.frame_end;
		end
		if (step) begin
			if (in_dec) begin
				win_a_q <= win_b_q;
				win_b_q <= newcol;
				fa_q    <= fb_q;
				fb_q    <= flag_rd;
				if (flush_q && WW'(col_q) != eff_w - WW'(1)) begin
					col_q <= col_q + CW'(1);
				end
			end else if (fend_q && !flush_q) begin
				// Bottom row sweep: the decided row moves down by one.
				row_q  <= row_q + ROW_BITS'(1);
				top_q  <= mid_q;
				mid_q  <= bot_q;
				botv_q <= 1'b0;
				col_q  <= '0;
			end
			if (has_dec) begin
				left_q <= is_max;
			end
			if (is_max) begin
				pend_row_q <= row_q;
				pend_col_q <= COLUMN_OUT_BITS'(dec_c);
				pend_val_q <= centre;
			end
		end
		if (step && is_max && pend_v_q) begin
			out_row_q  <= pend_row_q;
			out_col_q  <= pend_col_q;
			out_val_q  <= pend_val_q;
			out_last_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_row_q  <= pend_row_q;
			out_col_q  <= pend_col_q;
			out_val_q  <= pend_val_q;
			out_last_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			flush_q  <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if ((step && is_max && pend_v_q) || (state_q == ST_FIN && out_free)) begin
				out_v_q <= 1'b1;
			end else if (maxima.ready) begin
				out_v_q <= 1'b0;
			end
			if (step && is_max) begin
				pend_v_q <= 1'b1;
			end else if (state_q == ST_FIN && out_free) begin
				pend_v_q <= 1'b0;
			end
			if (go_idle) begin
				flush_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= ST_DEC;
					end
				end
				ST_RD: begin
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (step) begin
						if (job_last) begin
							state_q <= go_idle ? ST_IDLE : ST_FIN;
						end else if (!flush_q || WW'(col_q) == eff_w - WW'(1)) begin
							state_q <= ST_END;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_END: begin
					if (step) begin
						if (job_last) begin
							state_q <= go_idle ? ST_IDLE : ST_FIN;
						end else begin
							flush_q <= 1'b1;
							state_q <= ST_RD;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule
